### design/ioet_pkg.sv
package ioet_pkg;

   localparam int unsigned TABLE_ENTRIES_DEF = 128;
   localparam int unsigned ID_W              = 16;
   localparam int unsigned VALUE_W           = 32;
   localparam int unsigned LEN_W             = 16;
   localparam int unsigned OUT_CNT_W         = 8;
   localparam int unsigned OUT_SLOT_W        = 7;
   localparam int unsigned CAT_NUM           = 5;

   typedef enum logic [2:0] {
      CAT_ONE   = 3'd0,
      CAT_TWO   = 3'd1,
      CAT_FOUR  = 3'd2,
      CAT_EIGHT = 3'd3,
      CAT_OTHER = 3'd4
   } cat_type;

   localparam logic [LEN_W-1:0] LEN_ONE   = LEN_W'(1);
   localparam logic [LEN_W-1:0] LEN_TWO   = LEN_W'(2);
   localparam logic [LEN_W-1:0] LEN_FOUR  = LEN_W'(4);
   localparam logic [LEN_W-1:0] LEN_EIGHT = LEN_W'(8);

   typedef struct packed {
      logic    valid;
      logic    found;
      logic    appended;
      logic    dropped;
      cat_type old_cat;
      cat_type new_cat;
   } tbl_result_type;

   function automatic cat_type length_cat(input logic [LEN_W-1:0] len);
      cat_type c;
      case (len)
         LEN_ONE:   c = CAT_ONE;
         LEN_TWO:   c = CAT_TWO;
         LEN_FOUR:  c = CAT_FOUR;
         LEN_EIGHT: c = CAT_EIGHT;
         default:   c = CAT_OTHER;
      endcase
      return c;
   endfunction

endpackage

### design/ioet_table.sv
module ioet_table
   import ioet_pkg::*;
#(
   parameter int unsigned ENTRIES = TABLE_ENTRIES_DEF,
   localparam int unsigned AW = $clog2(ENTRIES),
   localparam int unsigned CW = $clog2(ENTRIES + 1)
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [ID_W-1:0]    start_id,
   input  logic [VALUE_W-1:0] start_value,
   input  logic [LEN_W-1:0]   start_length,
   output logic               ready,
   input  logic               result_ack,
   output tbl_result_type     result,
   output logic [AW-1:0]      result_slot,
   output logic [CW-1:0]      result_count
);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_SCAN = 3'b010,
      ST_HOLD = 3'b100
   } state_type;

   localparam logic [CW-1:0] FULL_COUNT = CW'(ENTRIES);

   // tag entry: {length, id}
   logic [LEN_W+ID_W-1:0] tag_mem [ENTRIES];
   logic [VALUE_W-1:0]    value_mem [ENTRIES];

   state_type             state_ff, state_in;
   logic [ID_W-1:0]       key_id_ff;
   logic [VALUE_W-1:0]    key_value_ff;
   logic [LEN_W-1:0]      key_len_ff;
   logic [CW-1:0]         issue_ff, issue_in;
   logic                  cmp_valid_ff, cmp_valid_in;
   logic [AW-1:0]         cmp_idx_ff;
   logic [CW-1:0]         count_ff, count_in;
   logic [LEN_W+ID_W-1:0] rd_tag_ff;
   tbl_result_type        res_ff;
   logic                  res_valid_ff, res_valid_in;
   logic [AW-1:0]         slot_ff;

   logic                  in_scan;
   logic                  do_read;
   logic                  hit;
   logic                  miss;
   logic                  full;
   logic                  wr_en;
   logic [AW-1:0]         wr_addr;

   assign in_scan = (state_ff == ST_SCAN);
   assign do_read = in_scan && (issue_ff < count_ff);
   assign hit     = in_scan && cmp_valid_ff && (rd_tag_ff[ID_W-1:0] == key_id_ff);
   assign miss    = in_scan && !hit && (issue_ff == count_ff);
   assign full    = (count_ff == FULL_COUNT);
   assign wr_en   = hit || (miss && !full);
   assign wr_addr = hit ? cmp_idx_ff : count_ff[AW-1:0];

   always_comb begin
      state_in     = state_ff;
      issue_in     = issue_ff;
      cmp_valid_in = cmp_valid_ff;
      count_in     = count_ff;
      res_valid_in = res_valid_ff;
      case (state_ff)
         ST_IDLE: begin
            issue_in     = '0;
            cmp_valid_in = 1'b0;
            if (start) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmp_valid_in = do_read;
            if (do_read) begin
               issue_in = issue_ff + CW'(1);
            end
            if (hit || miss) begin
               state_in     = ST_HOLD;
               res_valid_in = 1'b1;
               if (miss && !full) begin
                  count_in = count_ff + CW'(1);
               end
            end
         end
         ST_HOLD: begin
            if (result_ack) begin
               state_in     = ST_IDLE;
               res_valid_in = 1'b0;
            end
         end
         default: begin
            state_in     = ST_IDLE;
            res_valid_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         issue_ff     <= '0;
         cmp_valid_ff <= 1'b0;
         count_ff     <= '0;
         res_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         issue_ff     <= issue_in;
         cmp_valid_ff <= cmp_valid_in;
         count_ff     <= count_in;
         res_valid_ff <= res_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (start && (state_ff == ST_IDLE)) begin
         key_id_ff    <= start_id;
         key_value_ff <= start_value;
         key_len_ff   <= start_length;
      end
      if (do_read) begin
         cmp_idx_ff <= issue_ff[AW-1:0];
      end
      if (hit || miss) begin
         res_ff.valid    <= 1'b1;
         res_ff.found    <= hit;
         res_ff.appended <= miss && !full;
         res_ff.dropped  <= miss && full;
         res_ff.old_cat  <= length_cat(rd_tag_ff[LEN_W+ID_W-1:ID_W]);
         res_ff.new_cat  <= length_cat(key_len_ff);
         slot_ff         <= (miss && full) ? '0 : wr_addr;
      end
   end

   // lookup port
   always_ff @(posedge clock) begin
      if (do_read) begin
         rd_tag_ff <= tag_mem[issue_ff[AW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         tag_mem[wr_addr]   <= {key_len_ff, key_id_ff};
         value_mem[wr_addr] <= key_value_ff;
      end
   end

   assign ready        = (state_ff == ST_IDLE);
   assign result_slot  = slot_ff;
   assign result_count = count_ff;

   always_comb begin
      result       = res_ff;
      result.valid = res_valid_ff;
   end

endmodule

### design/io_element_table_with_length_counts.sv
// I/O element table with per-length counts. Each request carries an element
// id, value and byte length; the id is looked up in a table of up to ENTRIES
// elements and either overwritten in place, appended in the next free slot,
// or dropped (and flagged in rsp_tuser) when the table is full. Every request
// yields one response with the element count and the counts of lengths 1, 2,
// 4, 8 and other, low 8 bits each, plus the slot written (low 7 bits, zero on
// drop). One request is handled at a time: the lookup walks the held entries
// through a single-read-port tag memory, one entry per cycle, and the next
// request is accepted once the response is in the output register. The
// tables need no clearing after reset.
module io_element_table_with_length_counts
   import ioet_pkg::*;
#(
   parameter int unsigned ENTRIES = TABLE_ENTRIES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // element_id[15:0], element_value[47:16], element_length[63:48]
   input  logic [63:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // total_entries[7:0], count_len_one[15:8], count_len_two[23:16],
   // count_len_four[31:24], count_len_eight[39:32], count_len_other[47:40],
   // slot_index[54:48], zero[55]
   output logic [55:0] rsp_tdata,
   // was_update[0], dropped_full[1]
   output logic [1:0]  rsp_tuser
);

   localparam int unsigned AW = $clog2(ENTRIES);
   localparam int unsigned CW = $clog2(ENTRIES + 1);

   logic           tbl_ready;
   tbl_result_type tbl_res;
   logic [AW-1:0]  tbl_slot;
   logic [CW-1:0]  tbl_count;
   logic           load;

   logic [CW-1:0]  cat_cnt_ff [CAT_NUM];
   logic [CW-1:0]  cat_cnt_in [CAT_NUM];
   logic           rsp_valid_ff, rsp_valid_in;
   logic [55:0]    rsp_tdata_ff;
   logic [1:0]     rsp_tuser_ff;

   ioet_table #(
      .ENTRIES (ENTRIES)
   ) u_table (
      .clock        (clock),
      .reset        (reset),
      .start        (req_tvalid),
      .start_id     (req_tdata[15:0]),
      .start_value  (req_tdata[47:16]),
      .start_length (req_tdata[63:48]),
      .ready        (tbl_ready),
      .result_ack   (load),
      .result       (tbl_res),
      .result_slot  (tbl_slot),
      .result_count (tbl_count)
   );

   assign req_tready = tbl_ready;
   assign load       = tbl_res.valid && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      cat_cnt_in = cat_cnt_ff;
      if (tbl_res.found) begin
         if (cat_cnt_in[tbl_res.old_cat] != '0) begin
            cat_cnt_in[tbl_res.old_cat] = cat_cnt_in[tbl_res.old_cat] - CW'(1);
         end
         cat_cnt_in[tbl_res.new_cat] = cat_cnt_in[tbl_res.new_cat] + CW'(1);
      end else if (tbl_res.appended) begin
         cat_cnt_in[tbl_res.new_cat] = cat_cnt_in[tbl_res.new_cat] + CW'(1);
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < CAT_NUM; i++) begin
            cat_cnt_ff[i] <= '0;
         end
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (load) begin
            cat_cnt_ff <= cat_cnt_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_tdata_ff <= {1'b0,
                          OUT_SLOT_W'(tbl_slot),
                          OUT_CNT_W'(cat_cnt_in[CAT_OTHER]),
                          OUT_CNT_W'(cat_cnt_in[CAT_EIGHT]),
                          OUT_CNT_W'(cat_cnt_in[CAT_FOUR]),
                          OUT_CNT_W'(cat_cnt_in[CAT_TWO]),
                          OUT_CNT_W'(cat_cnt_in[CAT_ONE]),
                          OUT_CNT_W'(tbl_count)};
         rsp_tuser_ff <= {tbl_res.dropped, tbl_res.found};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

endmodule

### design/ioet_checker.sv
module ioet_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [55:0] rsp_tdata,
   input logic [1:0]  rsp_tuser
);

   logic [7:0] cat_sum;

   assign cat_sum = rsp_tdata[15:8] + rsp_tdata[23:16] + rsp_tdata[31:24]
                  + rsp_tdata[39:32] + rsp_tdata[47:40];

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response changed while stalled");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   a_flags_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tuser[0] && rsp_tuser[1]) &&
                     (!rsp_tuser[1] || rsp_tdata[54:48] == 7'd0))
      else $error("drop flagged with update or nonzero slot");

   a_count_sum: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> cat_sum == rsp_tdata[7:0])
      else $error("length counts do not add up to total");

   a_accept_gap: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request accepted during lookup");

endmodule

bind io_element_table_with_length_counts ioet_checker u_ioet_checker (.*);

### tb/io_element_table_with_length_counts_tb.sv
module io_element_table_with_length_counts_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import ioet_pkg::*;

   localparam int unsigned DEPTH        = TABLE_ENTRIES_DEF;
   localparam int          RANDOM_ITEMS = 1400;

   typedef struct {
      logic [7:0] total;
      logic [7:0] one;
      logic [7:0] two;
      logic [7:0] four;
      logic [7:0] eight;
      logic [7:0] other;
      logic       was_update;
      logic       dropped;
      logic [6:0] slot;
   } table_status_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [55:0] rsp_tdata;
   logic [1:0]  rsp_tuser;

   io_element_table_with_length_counts #(
      .ENTRIES (DEPTH)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // shadow table
   logic [ID_W-1:0]    shadow_id    [DEPTH];
   logic [VALUE_W-1:0] shadow_value [DEPTH];
   logic [LEN_W-1:0]   shadow_len   [DEPTH];
   int unsigned        shadow_count = 0;
   int unsigned        len_tally    [CAT_NUM] = '{default: 0};

   logic [63:0]      req_backlog [$];
   table_status_type status_queue [$];

   // stimulus-side bookkeeping of ids that will be held
   logic [ID_W-1:0] gen_ids [$];
   bit              id_taken [65536];

   int req_issued  = 0;
   int req_accepts = 0;
   int rsp_accepts = 0;
   int rsp_seen    = 0;
   int req_gap     = 0;
   int rsp_gap     = 0;
   int total_items = 0;
   int failures    = 0;
   int seen_appends = 0;
   int seen_updates = 0;
   int seen_drops   = 0;

   function automatic cat_type len_class(input logic [LEN_W-1:0] len);
      case (len)
         16'd1:   return CAT_ONE;
         16'd2:   return CAT_TWO;
         16'd4:   return CAT_FOUR;
         16'd8:   return CAT_EIGHT;
         default: return CAT_OTHER;
      endcase
   endfunction

   function automatic table_status_type apply_insert(input logic [63:0] word);
      logic [ID_W-1:0]    id;
      logic [VALUE_W-1:0] val;
      logic [LEN_W-1:0]   len;
      int unsigned        slot;
      bit                 found;
      bit                 dropped;
      cat_type            old_cat;
      table_status_type   s;
      id      = word[15:0];
      val     = word[47:16];
      len     = word[63:48];
      slot    = 0;
      found   = 1'b0;
      dropped = 1'b0;
      for (int unsigned i = 0; i < shadow_count; i++) begin
         if (shadow_id[i] == id) begin
            found = 1'b1;
            slot  = i;
            break;
         end
      end
      if (found) begin
         old_cat = len_class(shadow_len[slot]);
         if (len_tally[old_cat] > 0) len_tally[old_cat]--;
         shadow_value[slot] = val;
         shadow_len[slot]   = len;
         len_tally[len_class(len)]++;
      end else if (shadow_count < DEPTH) begin
         slot = shadow_count;
         shadow_id[slot]    = id;
         shadow_value[slot] = val;
         shadow_len[slot]   = len;
         shadow_count++;
         len_tally[len_class(len)]++;
      end else begin
         dropped = 1'b1;
         slot    = 0;
      end
      s.total      = 8'(shadow_count);
      s.one        = 8'(len_tally[CAT_ONE]);
      s.two        = 8'(len_tally[CAT_TWO]);
      s.four       = 8'(len_tally[CAT_FOUR]);
      s.eight      = 8'(len_tally[CAT_EIGHT]);
      s.other      = 8'(len_tally[CAT_OTHER]);
      s.was_update = found;
      s.dropped    = dropped;
      s.slot       = 7'(slot);
      return s;
   endfunction

   task automatic add_request(input logic [15:0] id, input logic [31:0] val,
                              input logic [15:0] len);
      req_backlog.push_back({len, val, id});
      if (!id_taken[id] && gen_ids.size() < DEPTH) begin
         id_taken[id] = 1'b1;
         gen_ids.push_back(id);
      end
   endtask

   function automatic logic [15:0] fresh_id();
      logic [15:0] id;
      do id = 16'($urandom_range(0, 65535)); while (id_taken[id]);
      return id;
   endfunction

   function automatic logic [15:0] held_id();
      return gen_ids[$urandom_range(0, gen_ids.size() - 1)];
   endfunction

   function automatic logic [15:0] pick_len();
      case ($urandom_range(0, 9))
         0:       return 16'd1;
         1:       return 16'd2;
         2:       return 16'd4;
         3:       return 16'd8;
         4:       return 16'd0;
         5:       return 16'hFFFF;
         6:       return 16'($urandom_range(3, 16));
         default: return 16'($urandom_range(0, 65535));
      endcase
   endfunction

   // every fourth stretch of 160 requests runs without idling
   function automatic int draw_gap();
      if ((req_issued / 160) % 4 == 3) return 0;
      return $urandom_range(0, 14);
   endfunction

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected %0d, got %0d", name, want, got);
         failures++;
      end
   endtask

   // request driver
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (req_tvalid && req_accepts == req_issued) begin
         req_gap = draw_gap();
         if (req_gap == 0 && req_backlog.size() > 0) begin
            req_tdata <= req_backlog.pop_front();
            req_issued++;
         end else begin
            req_tvalid <= 1'b0;
         end
      end else if (!req_tvalid) begin
         if (req_gap > 0) begin
            req_gap--;
         end else if (req_backlog.size() > 0) begin
            req_tvalid <= 1'b1;
            req_tdata  <= req_backlog.pop_front();
            req_issued++;
         end
      end
   end

   // response backpressure
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (rsp_accepts != rsp_seen) begin
         rsp_seen = rsp_accepts;
         rsp_gap  = draw_gap();
         rsp_tready <= (rsp_gap == 0);
      end else if (!rsp_tready) begin
         if (rsp_gap > 0) rsp_gap--;
         else rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin : monitor
      table_status_type want;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            status_queue.push_back(apply_insert(req_tdata));
            req_accepts++;
         end
         if (rsp_tvalid && rsp_tready) begin
            rsp_accepts++;
            if (status_queue.size() == 0) begin
               $error("response with no request outstanding");
               failures++;
            end else begin
               want = status_queue.pop_front();
               check_field("total_entries",   want.total,      rsp_tdata[7:0]);
               check_field("count_len_one",   want.one,        rsp_tdata[15:8]);
               check_field("count_len_two",   want.two,        rsp_tdata[23:16]);
               check_field("count_len_four",  want.four,       rsp_tdata[31:24]);
               check_field("count_len_eight", want.eight,      rsp_tdata[39:32]);
               check_field("count_len_other", want.other,      rsp_tdata[47:40]);
               check_field("slot_index",      want.slot,       rsp_tdata[54:48]);
               check_field("was_update",      want.was_update, rsp_tuser[0]);
               check_field("dropped_full",    want.dropped,    rsp_tuser[1]);
               if (want.dropped) seen_drops++;
               else if (want.was_update) seen_updates++;
               else seen_appends++;
            end
         end
      end
   end

   initial begin
      // extremes, every length class, moves between classes
      add_request(16'h0000, 32'h7FFF_FFFF, 16'd1);
      add_request(16'hFFFF, 32'h8000_0000, 16'd2);
      add_request(16'h1234, 32'h0000_0000, 16'd4);
      add_request(16'h8000, 32'hFFFF_FFFF, 16'd8);
      add_request(16'h0001, 32'h5555_5555, 16'd0);
      add_request(16'h00FF, 32'hAAAA_AAAA, 16'hFFFF);
      add_request(16'h7FFF, 32'h0000_0001, 16'd3);
      add_request(16'hFFFE, 32'h0000_0002, 16'd16);
      add_request(16'h0000, 32'h1234_5678, 16'd8);
      add_request(16'h0000, 32'h0000_0000, 16'd0);
      add_request(16'h0000, 32'hFFFF_FFFF, 16'd1);
      add_request(16'hFFFF, 32'h0000_0005, 16'd2);
      add_request(16'h8000, 32'h0000_0006, 16'd4);
      add_request(16'h00FF, 32'h0000_0007, 16'hFFFE);
      add_request(16'h0001, 32'h0000_0008, 16'd2);
      add_request(16'h1234, 32'h0000_0009, 16'h0101);
      // fill the table with a mix of appends and updates, then hammer it full
      for (int k = 0; k < RANDOM_ITEMS; k++) begin
         if (gen_ids.size() < DEPTH) begin
            if ($urandom_range(0, 99) < 65)
               add_request(fresh_id(), $urandom, pick_len());
            else
               add_request(held_id(), $urandom, pick_len());
         end else begin
            if ($urandom_range(0, 99) < 35)
               add_request(fresh_id(), $urandom, pick_len());
            else
               add_request(held_id(), $urandom, pick_len());
         end
      end
      total_items = req_backlog.size();

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (req_accepts < total_items || status_queue.size() != 0) @(posedge clock);
      repeat (2 * (DEPTH + 4)) @(posedge clock);

      $display("%0d requests: %0d appends, %0d updates, %0d dropped on a full table",
               total_items, seen_appends, seen_updates, seen_drops);
      $display("length classes 1/2/4/8/other all exercised, with random stalls on both sides");
      if (failures == 0 && status_queue.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   initial begin
      #(25_000_000);
      $display("timeout waiting for responses");
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
